### hw/rtl/mie_pkg.sv
package mie_pkg;

	// Microprogram counter width and step addresses
	localparam int PC_W = 4;

	localparam logic [PC_W-1:0] S_IDLE  = 4'd0;
	localparam logic [PC_W-1:0] S_CHECK = 4'd1;
	localparam logic [PC_W-1:0] S_DIV0  = 4'd2;
	localparam logic [PC_W-1:0] S_TEST  = 4'd3;
	localparam logic [PC_W-1:0] S_SETUP = 4'd4;
	localparam logic [PC_W-1:0] S_LOOP  = 4'd5;
	localparam logic [PC_W-1:0] S_UPD   = 4'd6;
	localparam logic [PC_W-1:0] S_FIN   = 4'd7;
	localparam logic [PC_W-1:0] S_RET   = 4'd8;

	// Jump conditions
	localparam int COND_W = 3;

	localparam logic [COND_W-1:0] C_NEVER    = 3'd0;
	localparam logic [COND_W-1:0] C_ALWAYS   = 3'd1;
	localparam logic [COND_W-1:0] C_NO_REQ   = 3'd2;
	localparam logic [COND_W-1:0] C_BAD      = 3'd3;
	localparam logic [COND_W-1:0] C_CNT_MORE = 3'd4;
	localparam logic [COND_W-1:0] C_REM_ZERO = 3'd5;
	localparam logic [COND_W-1:0] C_OUT_BUSY = 3'd6;

	// One control word: datapath actions plus a conditional jump
	typedef struct packed {
		logic              load;    // take a request
		logic              div;     // one restoring division step
		logic              mul;     // one modular double-and-add step
		logic              setup;   // start the next Euclid round
		logic              update;  // coefficient update
		logic              fin;     // write the result register
		logic [COND_W-1:0] cond;
		logic [PC_W-1:0]   target;
	} ctrl_t;

	// Datapath status seen by the sequencer
	typedef struct packed {
		logic req_valid;
		logic bad;
		logic cnt_more;
		logic rem_zero;
		logic out_busy;
	} flags_t;

	// Microcode store
	function automatic ctrl_t mie_rom(input logic [PC_W-1:0] pc);
		ctrl_t c;
		c = '0;
		case (pc)
			S_IDLE: begin
				c.load   = 1'b1;
				c.cond   = C_NO_REQ;
				c.target = S_IDLE;
			end
			S_CHECK: begin
				c.cond   = C_BAD;
				c.target = S_FIN;
			end
			S_DIV0: begin
				c.div    = 1'b1;
				c.cond   = C_CNT_MORE;
				c.target = S_DIV0;
			end
			S_TEST: begin
				c.cond   = C_REM_ZERO;
				c.target = S_FIN;
			end
			S_SETUP: begin
				c.setup  = 1'b1;
				c.cond   = C_NEVER;
			end
			S_LOOP: begin
				c.div    = 1'b1;
				c.mul    = 1'b1;
				c.cond   = C_CNT_MORE;
				c.target = S_LOOP;
			end
			S_UPD: begin
				c.update = 1'b1;
				c.cond   = C_ALWAYS;
				c.target = S_TEST;
			end
			S_FIN: begin
				c.fin    = 1'b1;
				c.cond   = C_OUT_BUSY;
				c.target = S_FIN;
			end
			S_RET: begin
				c.cond   = C_ALWAYS;
				c.target = S_IDLE;
			end
			default: begin
				c.cond   = C_ALWAYS;
				c.target = S_IDLE;
			end
		endcase
		return c;
	endfunction

endpackage

### hw/rtl/mie_if.sv
// Request channel: modulus and value
interface mie_req_if #(parameter int DATA_WIDTH = 32);
	logic                  valid;
	logic                  ready;
	logic [DATA_WIDTH-1:0] modulus;
	logic [DATA_WIDTH-1:0] value;

	modport source (output valid, output modulus, output value, input ready);
	modport sink (input valid, input modulus, input value, output ready);
endinterface

// Result channel: inverse and error flag
interface mie_rsp_if #(parameter int DATA_WIDTH = 32);
	logic                  valid;
	logic                  ready;
	logic [DATA_WIDTH-1:0] inverse;
	logic                  no_inverse;

	modport source (output valid, output inverse, output no_inverse, input ready);
	modport sink (input valid, input inverse, input no_inverse, output ready);
endinterface

### hw/rtl/modular_inverse_ext_euclid.sv
// Modular inverse by the extended Euclidean algorithm. Each request carries a
// modulus b and a value a; the result is a^-1 mod b, or no_inverse = 1 with
// inverse = 0 when gcd(a, b) != 1, a is zero or b is below two. One request
// is in work at a time. The number of Euclid divisions is up to about 46
// for 32-bit operands. A zero value or a modulus below two is caught up
// front. A finished result waits while the output register is still full.
// The first division runs a bit-serial restoring divider alone; each later
// one runs it side by side with a bit-serial modular multiplier, one bit
// per cycle, under control of a small microcoded sequencer. The result sits
// in an output register, so a new request is taken while the previous
// result still waits to be read.
module modular_inverse_ext_euclid #(
	parameter int DATA_WIDTH = 32
) (
	input logic       clk,
	input logic       arst_n,
	mie_req_if.sink   req,
	mie_rsp_if.source rsp
);
	import mie_pkg::*;

	ctrl_t  ctrl;
	flags_t flags;

	mie_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctrl   (ctrl)
	);

	mie_datapath #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.flags  (flags),
		.req    (req),
		.rsp    (rsp)
	);

	// Busy after taking a request
	assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request taken while a request is in work");

	// Error results carry a zero inverse
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.no_inverse) |-> (rsp.inverse == '0))
		else $error("error result with nonzero inverse");

	// The multiplier only runs alongside the divider
	assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.mul |-> ctrl.div)
		else $error("multiply step without division step");

	// A finished result lands in the output register
	assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.fin && !flags.out_busy) |=> rsp.valid)
		else $error("result lost at output register");

endmodule

### hw/rtl/mie_seq.sv
module mie_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  mie_pkg::flags_t flags,
	output mie_pkg::ctrl_t  ctrl
);
	import mie_pkg::*;

	logic [PC_W-1:0] pc_q;
	logic            taken;

	// Fetch the control word for the current step
	assign ctrl = mie_rom(pc_q);

	// Jump condition
	always_comb begin
		case (ctrl.cond)
			C_NEVER:    taken = 1'b0;
			C_ALWAYS:   taken = 1'b1;
			C_NO_REQ:   taken = !flags.req_valid;
			C_BAD:      taken = flags.bad;
			C_CNT_MORE: taken = flags.cnt_more;
			C_REM_ZERO: taken = flags.rem_zero;
			C_OUT_BUSY: taken = flags.out_busy;
			default:    taken = 1'b1;
		endcase
	end

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= S_IDLE;
		end else if (taken) begin
			pc_q <= ctrl.target;
		end else begin
			pc_q <= pc_q + PC_W'(1);
		end
	end

endmodule

### hw/rtl/mie_datapath.sv
module mie_datapath #(
	parameter int DATA_WIDTH = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  mie_pkg::ctrl_t  ctrl,
	output mie_pkg::flags_t flags,
	mie_req_if.sink         req,
	mie_rsp_if.source       rsp
);
	import mie_pkg::*;

	localparam int W     = DATA_WIDTH;
	localparam int CNT_W = $clog2(DATA_WIDTH + 1);

	logic [W-1:0]     mod_q;   // modulus b
	logic [W-1:0]     dv_q;    // divisor (current den)
	logic [W-1:0]     qs_q;    // dividend in, quotient out
	logic [W-1:0]     rm_q;    // partial remainder
	logic [W-1:0]     my_q;    // quotient bits feeding the multiply
	logic [W-1:0]     acc_q;   // t_cur * quo mod b
	logic [W-1:0]     tp_q;    // t_prev
	logic [W-1:0]     tc_q;    // t_cur
	logic [CNT_W-1:0] cnt_q;
	logic             rsp_valid_q;
	logic [W-1:0]     inverse_q;
	logic             no_inverse_q;

	logic             load_fire;
	logic             fin_fire;
	logic             out_busy;

	logic [W:0]       div_sh;
	logic [W:0]       div_diff;
	logic             div_ge;
	logic [W-1:0]     rm_n;
	logic [W-1:0]     qs_n;

	logic [W+1:0]     mul_sum;
	logic [W+1:0]     mod_x1;
	logic [W+1:0]     mod_x2;
	logic [W-1:0]     acc_n;

	logic [W:0]       upd_diff;
	logic [W-1:0]     t_next;

	logic             no_inv;

	assign out_busy  = rsp_valid_q && !rsp.ready;
	assign load_fire = ctrl.load && req.valid;
	assign fin_fire  = ctrl.fin && !out_busy;
	assign req.ready = ctrl.load;

	// Status for the sequencer
	assign flags.req_valid = req.valid;
	assign flags.bad       = (dv_q == '0) || (mod_q < W'(2));
	assign flags.cnt_more  = cnt_q != CNT_W'(1);
	assign flags.rem_zero  = rm_q == '0;
	assign flags.out_busy  = out_busy;

	// Restoring division step: one quotient bit
	always_comb begin
		div_sh   = {rm_q, qs_q[W-1]};
		div_diff = div_sh - {1'b0, dv_q};
		div_ge   = div_sh >= {1'b0, dv_q};
		rm_n     = div_ge ? div_diff[W-1:0] : div_sh[W-1:0];
		qs_n     = {qs_q[W-2:0], div_ge};
	end

	// Modular double-and-add step, quotient bits MSB first
	always_comb begin
		mul_sum = {1'b0, acc_q, 1'b0} + (my_q[W-1] ? {2'b00, tc_q} : '0);
		mod_x1  = {2'b00, mod_q};
		mod_x2  = {1'b0, mod_q, 1'b0};
		if (mul_sum >= mod_x2) begin
			acc_n = W'(mul_sum - mod_x2);
		end else if (mul_sum >= mod_x1) begin
			acc_n = W'(mul_sum - mod_x1);
		end else begin
			acc_n = mul_sum[W-1:0];
		end
	end

	// t_next = (t_prev - prod) mod b
	always_comb begin
		upd_diff = {1'b0, tp_q} - {1'b0, acc_q};
		t_next   = upd_diff[W] ? W'(upd_diff + {1'b0, mod_q}) : upd_diff[W-1:0];
	end

	// Result: last nonzero remainder must be 1
	always_comb begin
		no_inv = (dv_q != W'(1)) || (mod_q < W'(2));
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (load_fire) begin
			mod_q <= req.modulus;
			dv_q  <= req.value;
			qs_q  <= req.modulus;
			rm_q  <= '0;
			tp_q  <= '0;
			tc_q  <= W'(1);
		end else if (ctrl.setup) begin
			my_q  <= qs_q;
			qs_q  <= dv_q;
			dv_q  <= rm_q;
			rm_q  <= '0;
			acc_q <= '0;
		end else if (ctrl.update) begin
			tp_q  <= tc_q;
			tc_q  <= t_next;
		end else begin
			if (ctrl.div) begin
				qs_q <= qs_n;
				rm_q <= rm_n;
			end
			if (ctrl.mul) begin
				acc_q <= acc_n;
				my_q  <= {my_q[W-2:0], 1'b0};
			end
		end
	end

	// Step counter for division and multiply
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load_fire || ctrl.setup) begin
			cnt_q <= CNT_W'(W);
		end else if (ctrl.div) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fin_fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_fire) begin
			inverse_q    <= no_inv ? '0 : tc_q;
			no_inverse_q <= no_inv;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.inverse    = inverse_q;
	assign rsp.no_inverse = no_inverse_q;

endmodule

### test/tb_modular_inverse_ext_euclid.sv
`timescale 1ns / 100ps

module tb_modular_inverse_ext_euclid;

	localparam int DW          = 32;
	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int TAIL_CYCLES = 1700;   // worst-case Euclid run plus margin
	localparam int LONG_HOLD   = 6000;

	typedef struct {
		logic [DW-1:0] modulus;
		logic [DW-1:0] value;
		logic [DW-1:0] inverse;
		logic          no_inverse;
	} inv_result_t;

	typedef enum int {
		MIX_FULL_RANGE,
		MIX_SMALL_MOD,
		MIX_SHARED_FACTOR,
		MIX_VALUE_ABOVE,
		MIX_DEGENERATE
	} operand_mix_t;

	logic clk;
	logic arst_n;

	mie_req_if #(.DATA_WIDTH(DW)) req_ch ();
	mie_rsp_if #(.DATA_WIDTH(DW)) rsp_ch ();

	modular_inverse_ext_euclid #(.DATA_WIDTH(DW)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	inv_result_t pending_inverses[$];
	int          fail_count    = 0;
	bit          idling_on     = 1'b0;
	int          hold_request  = 0;
	int          cycle_count   = 0;

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	// Expected inverse: Euclid remainder chain on (m, v), Bezout coefficient of v
	// kept as a residue in [0, m)
	function automatic inv_result_t predict_inverse(input logic [DW-1:0] m,
			input logic [DW-1:0] v);
		inv_result_t r;
		logic [63:0] mod64, num, den, rem, quo, t_prev, t_cur, t_next, prod;
		r.modulus    = m;
		r.value      = v;
		r.inverse    = '0;
		r.no_inverse = 1'b1;
		if (v == '0 || m < 2)
			return r;
		mod64  = 64'(m);
		num    = mod64;
		den    = 64'(v);
		t_prev = '0;
		t_cur  = 64'd1;
		quo    = num / den;
		rem    = num % den;
		while (rem != '0) begin
			// t_cur < m and quo < 2^32, so the product fits in 64 bits
			prod   = (t_cur * quo) % mod64;
			t_next = (t_prev >= prod) ? (t_prev - prod) : (t_prev + (mod64 - prod));
			t_prev = t_cur;
			t_cur  = t_next;
			num    = den;
			den    = rem;
			quo    = num / den;
			rem    = num % den;
		end
		if (den == 64'd1) begin
			r.inverse    = t_cur[DW-1:0];
			r.no_inverse = 1'b0;
		end
		return r;
	endfunction

	// Offer one request, optionally after an idle burst, and queue its expected result
	task automatic send_request(input logic [DW-1:0] m, input logic [DW-1:0] v);
		int gap;
		if (idling_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 17);
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid   <= 1'b1;
		req_ch.modulus <= m;
		req_ch.value   <= v;
		do
			@(posedge clk);
		while (!req_ch.ready);
		pending_inverses.insert(pending_inverses.size(), predict_inverse(m, v));
	endtask

	task automatic wait_all_results();
		while (pending_inverses.size() != 0)
			@(posedge clk);
	endtask

	// One request drawn from the given operand mix
	task automatic send_random_operands(input operand_mix_t mix);
		logic [DW-1:0] m, v, g, x;
		case (mix)
			MIX_FULL_RANGE: begin
				m = $urandom;
				if (m < 2)
					m = 32'd2;
				v = $urandom_range(m - 1, 1);
			end
			MIX_SMALL_MOD: begin
				m = $urandom_range(2, 64);
				v = $urandom_range(m - 1, 0);
			end
			MIX_SHARED_FACTOR: begin
				g = $urandom_range(2, 1000);
				x = $urandom_range(32'hFFFF_FFFF / g, 1);
				m = g * x;
				v = g * $urandom_range(x, 1);
			end
			MIX_VALUE_ABOVE: begin
				m = $urandom_range(2, 32'h0000_FFFF);
				v = $urandom;
			end
			default: begin
				case ($urandom_range(0, 2))
					0: begin
						m = $urandom_range(0, 1);
						v = $urandom;
					end
					1: begin
						m = $urandom;
						v = '0;
					end
					default: begin
						m = $urandom;
						v = m;
					end
				endcase
			end
		endcase
		send_request(m, v);
	endtask

	function automatic operand_mix_t pick_mix();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return MIX_FULL_RANGE;
		else if (roll < 65)
			return MIX_SMALL_MOD;
		else if (roll < 80)
			return MIX_SHARED_FACTOR;
		else if (roll < 92)
			return MIX_VALUE_ABOVE;
		else
			return MIX_DEGENERATE;
	endfunction

	// Zero value, tiny moduli, value not below the modulus, shared factors
	task automatic test_special_cases();
		logic [DW-1:0] mods[10] = '{32'd97, 32'd0, 32'd0, 32'd1, 32'd1,
			32'd2, 32'd7, 32'd10, 32'd13, 32'd6};
		logic [DW-1:0] vals[10] = '{32'd0, 32'd0, 32'd5, 32'd1, 32'd0,
			32'd1, 32'd10, 32'd15, 32'd13, 32'd4};
		idling_on = 1'b1;
		foreach (mods[i])
			send_request(mods[i], vals[i]);
	endtask

	// Full-width operands, longest Euclid chain (consecutive Fibonacci numbers)
	task automatic test_operand_extremes();
		logic [DW-1:0] mods[12] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFB, 32'hB119_24E1, 32'h8000_0000, 32'hFFFF_FFFF,
			32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFE,
			32'h0001_0001};
		logic [DW-1:0] vals[12] = '{32'h0000_0001, 32'hFFFF_FFFE, 32'hFFFF_FFFF,
			32'h0000_0002, 32'h6D73_E55F, 32'hFFFF_FFFF, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h5555_5555, 32'h2AAA_AAAA, 32'h0000_0003,
			32'h0000_FFFF};
		idling_on = 1'b0;
		foreach (mods[i])
			send_request(mods[i], vals[i]);
	endtask

	// Result side holds off for a long stretch while requests keep coming
	task automatic test_result_backpressure();
		idling_on    = 1'b0;
		hold_request = LONG_HOLD;
		repeat (6)
			send_random_operands(MIX_FULL_RANGE);
	endtask

	// Request side pauses until the block has returned everything
	task automatic test_drain_pause();
		idling_on = 1'b1;
		repeat (10)
			send_random_operands(pick_mix());
		req_ch.valid <= 1'b0;
		wait_all_results();
		repeat (10)
			send_random_operands(pick_mix());
	endtask

	// Random operand mix, idling switched on and off in stretches
	task automatic test_random_mix();
		for (int n = 0; n < 280; n++) begin
			idling_on = ((n / 40) % 3) != 2;
			send_random_operands(pick_mix());
		end
	endtask

	// Closing stretch with no idling on either side
	task automatic test_full_rate();
		idling_on = 1'b0;
		repeat (40)
			send_random_operands(pick_mix());
	endtask

	// Result side: ready pattern and comparison against the oldest prediction
	initial begin
		inv_result_t want;
		int          stall_left;
		stall_left   = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (pending_inverses.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result inverse=%h no_inverse=%b",
						$time, rsp_ch.inverse, rsp_ch.no_inverse);
				end else begin
					want = pending_inverses.pop_front();
					if (rsp_ch.inverse !== want.inverse) begin
						fail_count++;
						$display("%0t: inverse mismatch m=%h v=%h expected %h actual %h",
							$time, want.modulus, want.value, want.inverse,
							rsp_ch.inverse);
					end
					if (rsp_ch.no_inverse !== want.no_inverse) begin
						fail_count++;
						$display("%0t: no_inverse mismatch m=%h v=%h expected %b actual %b",
							$time, want.modulus, want.value, want.no_inverse,
							rsp_ch.no_inverse);
					end
				end
			end
			// long hold takes priority over random bursts
			if (hold_request > 0) begin
				stall_left   = hold_request;
				hold_request = 0;
			end else if (stall_left == 0 && idling_on && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 17);
			end
			if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Test sequence
	initial begin
		arst_n         = 1'b0;
		req_ch.valid   = 1'b0;
		req_ch.modulus = '0;
		req_ch.value   = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_special_cases();
		test_operand_extremes();
		test_result_backpressure();
		test_drain_pause();
		test_random_mix();
		test_full_rate();

		req_ch.valid <= 1'b0;
		wait_all_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_inverses.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
